/* rtl/posq_pkg.sv */
// shared types and constants for the positional queue
`timescale 1ns / 1ps

package posq_pkg;

  // field widths fixed by the item format
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned STAT_W = 2;

  // default queue depth
  localparam int unsigned DEPTH_DEF = 16;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ   = 3'd0,
    CMD_DEQ   = 3'd1,
    CMD_INS   = 3'd2,
    CMD_DEL   = 3'd3,
    CMD_PEEK  = 3'd4,
    CMD_PEEKP = 3'd5
  } cmd_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_CAP,
    S_DEL_WR,
    S_PEEK_CAP,
    S_RESULT
  } state_e;

  // command item
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  item_id;
    logic [POS_W-1:0] position;
  } in_t;

  // result item
  typedef struct packed {
    logic [ID_W-1:0] result_id;
    status_e         status;
  } out_t;

endpackage

/* rtl/positional_queue_top.sv */
// positional queue: entry memory moved one entry per cycle by a small sequencer
`timescale 1ns / 1ps

// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o   in_data_i  (cmd, item_id, position)
// out      output     out_valid_o / out_stall_i out_data_o (result_id, status)
//
// enqueue, insert into an empty queue, errors and unused codes go from S_EXEC straight to
// S_RESULT, peeks through S_PEEK_CAP; other inserts, deletes and dequeues also move entries
// (at most DEPTH-1), one entry a cycle through the single write port of the entry memory
// reset clears the count and the control state; the entry memory is not cleared
// a finished result waits in the output register, so the next command is taken
// and worked on while out_stall_i holds the previous result

module positional_queue_top #(
  parameter int unsigned DEPTH = posq_pkg::DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  posq_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output posq_pkg::out_t out_data_o
);

  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned CPW = ((CW > posq_pkg::POS_W) ? CW : posq_pkg::POS_W) + 1;

  // entry memory
  logic [posq_pkg::ID_W-1:0] mem [DEPTH];
  logic [posq_pkg::ID_W-1:0] rd_data_q;
  logic [IW-1:0]             rd_addr;
  logic                      wr_en;
  logic [IW-1:0]             wr_addr;
  logic [posq_pkg::ID_W-1:0] wr_data;

  // control and payload registers
  posq_pkg::state_e           state_q, state_d;
  logic [CW-1:0]              count_q, count_d;
  logic [posq_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic [posq_pkg::ID_W-1:0]  id_q, id_d;
  logic [posq_pkg::POS_W-1:0] pos_q, pos_d;
  logic [IW-1:0]              idx_q, idx_d;
  logic [posq_pkg::ID_W-1:0]  res_q, res_d;
  posq_pkg::status_e          st_q, st_d;
  logic                       out_valid_q, out_valid_d;
  posq_pkg::out_t             out_data_q, out_data_d;

  // derived compare values
  logic           full, empty;
  logic [CPW-1:0] pos_ext, cnt_ext, idx_ext;
  logic           pos_in_count, pos_below_count;
  logic           load_out;

  assign full            = (count_q == CW'(DEPTH));
  assign empty           = (count_q == '0);
  assign pos_ext         = CPW'(pos_q);
  assign cnt_ext         = CPW'(count_q);
  assign idx_ext         = CPW'(idx_q);
  assign pos_in_count    = (pos_q != '0) && (pos_ext <= cnt_ext);
  assign pos_below_count = (pos_q != '0) && (pos_ext < cnt_ext);
  assign load_out        = (state_q == posq_pkg::S_RESULT) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = (state_q != posq_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // memory write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  // sequencer: next state, datapath control, memory addresses
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    id_d        = id_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    res_d       = res_q;
    st_d        = st_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = id_q;

    // result transfer empties the output register
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      posq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_data_i.cmd;
          id_d    = in_data_i.item_id;
          pos_d   = in_data_i.position;
          res_d   = '0;
          st_d    = posq_pkg::ST_OK;
          state_d = posq_pkg::S_EXEC;
        end
      end

      // check the command and start its work
      posq_pkg::S_EXEC: begin
        state_d = posq_pkg::S_RESULT;
        unique case (cmd_q)
          posq_pkg::CMD_ENQ: begin
            if (full) begin
              st_d = posq_pkg::ST_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = IW'(count_q);
              count_d = count_q + CW'(1);
            end
          end
          posq_pkg::CMD_DEQ: begin
            if (empty) begin
              st_d = posq_pkg::ST_EMPTY;
            end else begin
              rd_addr = '0;
              idx_d   = '0;
              state_d = posq_pkg::S_DEL_CAP;
            end
          end
          posq_pkg::CMD_INS: begin
            if (full) begin
              st_d = posq_pkg::ST_FULL;
            end else if (empty) begin
              wr_en   = 1'b1;
              wr_addr = '0;
              count_d = CW'(1);
            end else if (!pos_in_count) begin
              st_d = posq_pkg::ST_RANGE;
            end else if (pos_ext == cnt_ext) begin
              idx_d   = IW'(pos_ext);
              state_d = posq_pkg::S_INS_PUT;
            end else begin
              rd_addr = IW'(cnt_ext - CPW'(1));
              idx_d   = IW'(count_q);
              state_d = posq_pkg::S_INS_WR;
            end
          end
          posq_pkg::CMD_DEL: begin
            if (empty) begin
              st_d = posq_pkg::ST_EMPTY;
            end else if (!pos_below_count) begin
              st_d = posq_pkg::ST_RANGE;
            end else begin
              rd_addr = IW'(pos_ext);
              idx_d   = IW'(pos_ext);
              state_d = posq_pkg::S_DEL_CAP;
            end
          end
          posq_pkg::CMD_PEEK: begin
            if (empty) begin
              st_d = posq_pkg::ST_EMPTY;
            end else begin
              rd_addr = '0;
              state_d = posq_pkg::S_PEEK_CAP;
            end
          end
          posq_pkg::CMD_PEEKP: begin
            if (empty) begin
              st_d = posq_pkg::ST_EMPTY;
            end else if (!pos_in_count) begin
              st_d = posq_pkg::ST_RANGE;
            end else begin
              rd_addr = IW'(pos_ext - CPW'(1));
              state_d = posq_pkg::S_PEEK_CAP;
            end
          end
          default: begin
            state_d = posq_pkg::S_RESULT;
          end
        endcase
      end

      // open the gap: move entry idx-1 up to idx, read the next one below
      posq_pkg::S_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = rd_data_q;
        idx_d   = IW'(idx_ext - CPW'(1));
        if (idx_ext > pos_ext + CPW'(1)) begin
          rd_addr = IW'(idx_ext - CPW'(2));
        end else begin
          state_d = posq_pkg::S_INS_PUT;
        end
      end

      // place the new id into the gap
      posq_pkg::S_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        count_d = count_q + CW'(1);
        state_d = posq_pkg::S_RESULT;
      end

      // take the removed entry, start closing the gap
      posq_pkg::S_DEL_CAP: begin
        res_d = rd_data_q;
        if (idx_ext + CPW'(1) < cnt_ext) begin
          rd_addr = IW'(idx_ext + CPW'(1));
          state_d = posq_pkg::S_DEL_WR;
        end else begin
          count_d = count_q - CW'(1);
          state_d = posq_pkg::S_RESULT;
        end
      end

      // close the gap: move entry idx+1 down to idx, read the next one above
      posq_pkg::S_DEL_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = rd_data_q;
        idx_d   = IW'(idx_ext + CPW'(1));
        if (idx_ext + CPW'(2) < cnt_ext) begin
          rd_addr = IW'(idx_ext + CPW'(2));
        end else begin
          count_d = count_q - CW'(1);
          state_d = posq_pkg::S_RESULT;
        end
      end

      posq_pkg::S_PEEK_CAP: begin
        res_d   = rd_data_q;
        state_d = posq_pkg::S_RESULT;
      end

      // hand the result to the output register once it is free
      posq_pkg::S_RESULT: begin
        if (load_out) begin
          out_valid_d          = 1'b1;
          out_data_d.result_id = res_q;
          out_data_d.status    = st_q;
          state_d              = posq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = posq_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= posq_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    id_q       <= id_d;
    pos_q      <= pos_d;
    idx_q      <= idx_d;
    res_q      <= res_d;
    st_q       <= st_d;
    out_data_q <= out_data_d;
  end

endmodule
